### rtl/core/gmdpf_pkg.sv
// shared types, codes and helper functions of the grid maze path finder
package gmdpf_pkg;

  localparam int MAX_DIM_DEF = 16;

  localparam logic [4:0] GRID_DIM_RESET = 5'd12;
  localparam logic [4:0] GRID_DIM_MIN   = 5'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [1:0] CFG_GRID_COLS = 2'd1;

  // opcodes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // result status codes
  localparam logic [2:0] ST_WRITE_DONE = 3'd0;
  localparam logic [2:0] ST_FOUND      = 3'd1;
  localparam logic [2:0] ST_NO_PATH    = 3'd2;
  localparam logic [2:0] ST_BLOCKED    = 3'd3;
  localparam logic [2:0] ST_READ_DATA  = 3'd4;

  // neighbor order, then the all-tried mark
  localparam logic [2:0] DIR_EAST  = 3'd0;
  localparam logic [2:0] DIR_WEST  = 3'd1;
  localparam logic [2:0] DIR_NORTH = 3'd2;
  localparam logic [2:0] DIR_SOUTH = 3'd3;
  localparam logic [2:0] DIR_DONE  = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] row;
    logic [3:0] col;
    logic       cell_open;
    logic [7:0] path_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [8:0] path_length;
    logic [3:0] out_row;
    logic [3:0] out_col;
  } out_item_t;

  // one path entry: the cell and the next neighbor to try from it
  typedef struct packed {
    logic [2:0] dir;
    logic [3:0] row;
    logic [3:0] col;
  } stk_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CLEAR,
    S_START_RD,
    S_START_CHK,
    S_PROBE,
    S_CHECK,
    S_POP_LD,
    S_FINISH
  } fsm_state_t;

  function automatic logic [4:0] clamp_dim(input logic [4:0] v, input logic [4:0] dim_max);
    logic [4:0] res;
    res = v;
    if (v < GRID_DIM_MIN) begin
      res = GRID_DIM_MIN;
    end else if (v > dim_max) begin
      res = dim_max;
    end
    return res;
  endfunction

  function automatic logic on_border(input logic [3:0] r, input logic [3:0] c,
                                     input logic [4:0] nr, input logic [4:0] nc);
    return (r == 4'd0) || (c == 4'd0) ||
           ({1'b0, r} == nr - 5'd1) || ({1'b0, c} == nc - 5'd1);
  endfunction

endpackage

### rtl/core/gmdpf_ram.sv
// generic single write port, single read port ram with registered read data
module gmdpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/grid_maze_dfs_path_finder.sv
// grid maze path finder: depth-first search over a cell map held in ram
//
// Commands enter on in_data when start is high and busy is low. A write
// command stores one cell as open or wall and answers in the next cycle;
// busy stays low, so writes go one per cycle. A read command reads the path
// ram, whose registered data is used in S_READ; the answer, with the requested
// path entry and the path length, is registered from there. A search first
// sweeps the cell ram to clear the visited marks, one cell a cycle, then walks
// the maze: each neighbor probe is a read and a check of the cell ram, and
// each back-up is a read of the path ram. Every answer is a one-cycle strobe
// on out_valid with out_data; the receiver cannot hold it off.
// Grid size is written through cfg_valid/cfg_ready, cfg_index, cfg_data (ready is always
// high); the user must do so only while no command is in flight, as the block does not enforce it.
// Synchronous reset returns to idle, sets rows and columns to 12 and empties
// the stored path; the cell map keeps whatever it held and must be written.
module grid_maze_dfs_path_finder
  import gmdpf_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data
);

  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int DW    = $clog2(CELLS + 1);
  localparam int SEW   = $bits(stk_entry_t);
  localparam logic [4:0] DIM_MAX = 5'(MAX_DIM);

  function automatic logic [AW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
    return AW'(int'(r) * MAX_DIM + int'(c));
  endfunction

  fsm_state_t state_r, state_nxt;

  logic [4:0]    rows_r, cols_r;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [DW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [3:0]    top_row_r, top_row_nxt, top_col_r, top_col_nxt;
  logic [2:0]    top_dir_r, top_dir_nxt;
  logic [3:0]    nbr_row_r, nbr_row_nxt, nbr_col_r, nbr_col_nxt;
  logic [7:0]    idx_r, idx_nxt;

  // cell ram: bit 1 open, bit 0 visited
  logic          cm_we;
  logic [AW-1:0] cm_waddr, cm_raddr;
  logic [1:0]    cm_wdata, cm_rdata;

  // path ram, indexed by position on the path
  logic          sm_we;
  logic [AW-1:0] sm_waddr, sm_raddr;
  stk_entry_t    sm_wdata, sm_rdata;

  logic       accept;
  logic [4:0] nr, nc;
  logic [4:0] nbr_r5, nbr_c5;
  logic       nbr_in, start_in, start_border, nbr_border, enter;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign nr = clamp_dim(rows_r, DIM_MAX);
  assign nc = clamp_dim(cols_r, DIM_MAX);

  assign start_in     = ({1'b0, top_row_r} < nr) && ({1'b0, top_col_r} < nc);
  assign start_border = on_border(top_row_r, top_col_r, nr, nc);
  assign nbr_border   = on_border(nbr_row_r, nbr_col_r, nr, nc);
  assign enter        = cm_rdata[1] && !cm_rdata[0];

  // neighbor of the top cell in the current direction, with grid bounds
  always_comb begin
    nbr_r5 = {1'b0, top_row_r};
    nbr_c5 = {1'b0, top_col_r};
    nbr_in = 1'b0;
    case (top_dir_r)
      DIR_EAST: begin
        nbr_c5 = {1'b0, top_col_r} + 5'd1;
        nbr_in = (nbr_c5 < nc);
      end
      DIR_WEST: begin
        nbr_c5 = {1'b0, top_col_r} - 5'd1;
        nbr_in = (top_col_r != 4'd0);
      end
      DIR_NORTH: begin
        nbr_r5 = {1'b0, top_row_r} - 5'd1;
        nbr_in = (top_row_r != 4'd0);
      end
      DIR_SOUTH: begin
        nbr_r5 = {1'b0, top_row_r} + 5'd1;
        nbr_in = (nbr_r5 < nr);
      end
      default: nbr_in = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_data.opcode == OP_SEARCH) begin
            state_nxt = S_CLEAR;
          end else if (in_data.opcode == OP_READ) begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: state_nxt = S_IDLE;
      S_CLEAR: begin
        if (clr_cnt_r == DW'(CELLS)) begin
          state_nxt = S_START_RD;
        end
      end
      S_START_RD: state_nxt = start_in ? S_START_CHK : S_IDLE;
      S_START_CHK: begin
        if (!cm_rdata[1] || start_border) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (top_dir_r == DIR_DONE) begin
          state_nxt = (depth_r == DW'(1)) ? S_IDLE : S_POP_LD;
        end else if (nbr_in) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (enter && nbr_border) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_PROBE;
        end
      end
      S_POP_LD: state_nxt = S_PROBE;
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath, ram ports and results
  always_comb begin
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    depth_nxt     = depth_r;
    clr_cnt_nxt   = clr_cnt_r;
    top_row_nxt   = top_row_r;
    top_col_nxt   = top_col_r;
    top_dir_nxt   = top_dir_r;
    nbr_row_nxt   = nbr_row_r;
    nbr_col_nxt   = nbr_col_r;
    idx_nxt       = idx_r;
    cm_we         = 1'b0;
    cm_waddr      = '0;
    cm_wdata      = '0;
    cm_raddr      = '0;
    sm_we         = 1'b0;
    sm_waddr      = '0;
    sm_wdata      = '0;
    sm_raddr      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            OP_WRITE: begin
              if (({1'b0, in_data.row} < DIM_MAX) && ({1'b0, in_data.col} < DIM_MAX)) begin
                cm_we    = 1'b1;
                cm_waddr = cell_addr(in_data.row, in_data.col);
                cm_wdata = {in_data.cell_open, 1'b0};
              end
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{status: ST_WRITE_DONE, path_length: '0,
                                out_row: '0, out_col: '0};
            end
            OP_SEARCH: begin
              top_row_nxt = in_data.row;
              top_col_nxt = in_data.col;
              depth_nxt   = '0;
              clr_cnt_nxt = '0;
            end
            OP_READ: begin
              idx_nxt  = in_data.path_index;
              sm_raddr = AW'(in_data.path_index);
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: ST_READ_DATA, path_length: 9'(depth_r),
                          out_row: '0, out_col: '0};
        if (9'(idx_r) < 9'(depth_r)) begin
          out_data_nxt.out_row = sm_rdata.row;
          out_data_nxt.out_col = sm_rdata.col;
        end
      end
      S_CLEAR: begin
        // read one cell ahead, write back the previous one with visited cleared
        cm_raddr    = AW'(clr_cnt_r);
        clr_cnt_nxt = clr_cnt_r + DW'(1);
        if (clr_cnt_r != '0) begin
          cm_we    = 1'b1;
          cm_waddr = AW'(clr_cnt_r - DW'(1));
          cm_wdata = {cm_rdata[1], 1'b0};
        end
      end
      S_START_RD: begin
        cm_raddr = cell_addr(top_row_r, top_col_r);
        if (!start_in) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_BLOCKED, path_length: '0, out_row: '0, out_col: '0};
        end
      end
      S_START_CHK: begin
        if (!cm_rdata[1]) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status: ST_BLOCKED, path_length: '0, out_row: '0, out_col: '0};
        end else begin
          cm_we       = 1'b1;
          cm_waddr    = cell_addr(top_row_r, top_col_r);
          cm_wdata    = 2'b11;
          depth_nxt   = DW'(1);
          top_dir_nxt = DIR_EAST;
          if (start_border) begin
            sm_we         = 1'b1;
            sm_waddr      = '0;
            sm_wdata      = '{dir: DIR_EAST, row: top_row_r, col: top_col_r};
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: ST_FOUND, path_length: 9'd1, out_row: '0, out_col: '0};
          end
        end
      end
      S_PROBE: begin
        if (top_dir_r == DIR_DONE) begin
          depth_nxt = depth_r - DW'(1);
          if (depth_r == DW'(1)) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{status: ST_NO_PATH, path_length: '0, out_row: '0, out_col: '0};
          end else begin
            // parent entry becomes the new top
            sm_raddr = AW'(depth_r - DW'(2));
          end
        end else begin
          top_dir_nxt = top_dir_r + 3'd1;
          nbr_row_nxt = nbr_r5[3:0];
          nbr_col_nxt = nbr_c5[3:0];
          cm_raddr    = cell_addr(nbr_r5[3:0], nbr_c5[3:0]);
        end
      end
      S_CHECK: begin
        if (enter) begin
          cm_we       = 1'b1;
          cm_waddr    = cell_addr(nbr_row_r, nbr_col_r);
          cm_wdata    = 2'b11;
          // park the current top with its next direction, then step in
          sm_we       = 1'b1;
          sm_waddr    = AW'(depth_r - DW'(1));
          sm_wdata    = '{dir: top_dir_r, row: top_row_r, col: top_col_r};
          top_row_nxt = nbr_row_r;
          top_col_nxt = nbr_col_r;
          top_dir_nxt = DIR_EAST;
          depth_nxt   = depth_r + DW'(1);
        end
      end
      S_POP_LD: begin
        top_row_nxt = sm_rdata.row;
        top_col_nxt = sm_rdata.col;
        top_dir_nxt = sm_rdata.dir;
      end
      S_FINISH: begin
        sm_we         = 1'b1;
        sm_waddr      = AW'(depth_r - DW'(1));
        sm_wdata      = '{dir: DIR_EAST, row: top_row_r, col: top_col_r};
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: ST_FOUND, path_length: 9'(depth_r), out_row: '0, out_col: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      depth_r     <= '0;
      rows_r      <= GRID_DIM_RESET;
      cols_r      <= GRID_DIM_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      depth_r     <= depth_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_GRID_ROWS) begin
          rows_r <= cfg_data;
        end else if (cfg_index == CFG_GRID_COLS) begin
          cols_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    clr_cnt_r  <= clr_cnt_nxt;
    top_row_r  <= top_row_nxt;
    top_col_r  <= top_col_nxt;
    top_dir_r  <= top_dir_nxt;
    nbr_row_r  <= nbr_row_nxt;
    nbr_col_r  <= nbr_col_nxt;
    idx_r      <= idx_nxt;
  end

  gmdpf_ram #(
    .WIDTH(2),
    .DEPTH(CELLS)
  ) u_cell_ram (
    .clk  (clk),
    .we   (cm_we),
    .waddr(cm_waddr),
    .wdata(cm_wdata),
    .raddr(cm_raddr),
    .rdata(cm_rdata)
  );

  gmdpf_ram #(
    .WIDTH(SEW),
    .DEPTH(CELLS)
  ) u_path_ram (
    .clk  (clk),
    .we   (sm_we),
    .waddr(sm_waddr),
    .wdata(sm_wdata),
    .raddr(sm_raddr),
    .rdata(sm_rdata)
  );

  // path never grows beyond the cell count
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(CELLS))
    else $error("path depth beyond cell count");

  // the walk only runs with a cell on the path
  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE || state_r == S_CHECK) |-> depth_r != '0)
    else $error("walk running on an empty path");

  // a found path always holds at least the start cell
  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FOUND) |-> out_data.path_length != '0)
    else $error("found path with zero length");

  // a cell write answers in the next cycle
  a_write_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.opcode == OP_WRITE) |=>
      (out_valid && out_data.status == ST_WRITE_DONE))
    else $error("cell write not answered");

endmodule

### dv/tb.sv
// testbench for the grid maze path finder: random mazes, searches and path reads
module tb;
  import gmdpf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = MAX_DIM_DEF;
  localparam int CELLS = DIM * DIM;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 900;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_data = '0;
  logic       out_valid;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;

  grid_maze_dfs_path_finder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // maze state mirrored from the commands sent so far
  logic [4:0] rows_cfg = GRID_DIM_RESET;
  logic [4:0] cols_cfg = GRID_DIM_RESET;
  bit         cell_is_open[CELLS];
  bit         seen[CELLS];
  int         route[CELLS];
  int         next_try[CELLS];
  int         route_len = 0;
  // east, west, north, south
  int         step_row[4] = '{0, 0, -1, 1};
  int         step_col[4] = '{1, -1, 0, 0};

  in_item_t   pending_items[$];
  out_item_t  expected_answers[$];
  out_item_t  oldest_answer;
  int         error_count = 0;
  int         item_total = 0;
  int         burst_left = 6;
  int         gap_left = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int dim_in_use(logic [4:0] v);
    if (v < 5'd2) return 2;
    if (v > DIM) return DIM;
    return int'(v);
  endfunction

  function automatic bit is_edge_cell(int r, int c, int nr, int nc);
    return r == 0 || c == 0 || r == nr - 1 || c == nc - 1;
  endfunction

  // depth-first walk with full backtracking; visited marks stay set
  function automatic logic [2:0] trace_path(int r0, int c0);
    int nr, nc, top, d, r, c, cell_id;
    nr = dim_in_use(rows_cfg);
    nc = dim_in_use(cols_cfg);
    foreach (seen[i]) seen[i] = 1'b0;
    route_len = 0;
    if (r0 >= nr || c0 >= nc) return ST_BLOCKED;
    cell_id = r0 * DIM + c0;
    if (!cell_is_open[cell_id]) return ST_BLOCKED;
    seen[cell_id] = 1'b1;
    next_try[cell_id] = DIR_EAST;
    route[0] = cell_id;
    route_len = 1;
    if (is_edge_cell(r0, c0, nr, nc)) return ST_FOUND;
    while (route_len > 0) begin
      top = route[route_len - 1];
      d = next_try[top];
      if (d >= DIR_DONE) begin
        route_len--;
        continue;
      end
      next_try[top] = d + 1;
      r = top / DIM + step_row[d];
      c = top % DIM + step_col[d];
      if (r < 0 || c < 0 || r >= nr || c >= nc) continue;
      cell_id = r * DIM + c;
      if (!cell_is_open[cell_id] || seen[cell_id]) continue;
      seen[cell_id] = 1'b1;
      next_try[cell_id] = DIR_EAST;
      route[route_len] = cell_id;
      route_len++;
      if (is_edge_cell(r, c, nr, nc)) return ST_FOUND;
    end
    return ST_NO_PATH;
  endfunction

  task automatic predict_answer(in_item_t it);
    out_item_t ans;
    logic [2:0] st;
    ans = '0;
    case (it.opcode)
      OP_WRITE: begin
        cell_is_open[int'(it.row) * DIM + int'(it.col)] = it.cell_open;
        ans.status = ST_WRITE_DONE;
      end
      OP_SEARCH: begin
        st = trace_path(int'(it.row), int'(it.col));
        if (st != ST_FOUND) route_len = 0;
        ans.status = st;
        ans.path_length = 9'(route_len);
      end
      OP_READ: begin
        ans.status = ST_READ_DATA;
        ans.path_length = 9'(route_len);
        if (int'(it.path_index) < route_len) begin
          ans.out_row = 4'(route[it.path_index] / DIM);
          ans.out_col = 4'(route[it.path_index] % DIM);
        end
      end
      default: ;
    endcase
    if (it.opcode != OP_UNUSED) expected_answers.push_back(ans);
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [8:0] got, logic [8:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  task automatic new_burst();
    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
  endtask

  // command driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_answer(in_data);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          start <= 1'b1;
          burst_left--;
          if (burst_left <= 0) new_burst();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, status %0d",
                                  out_data.status));
      end else begin
        oldest_answer = expected_answers.pop_front();
        check_field("status", 9'(out_data.status), 9'(oldest_answer.status));
        check_field("path_length", out_data.path_length, oldest_answer.path_length);
        check_field("out_row", 9'(out_data.out_row), 9'(oldest_answer.out_row));
        check_field("out_col", 9'(out_data.out_col), 9'(oldest_answer.out_col));
      end
    end
  end

  task automatic push_item(logic [1:0] op, logic [3:0] r, logic [3:0] c, logic open_bit,
                           logic [7:0] idx);
    in_item_t it;
    it.opcode = op;
    it.row = r;
    it.col = c;
    it.cell_open = open_bit;
    it.path_index = idx;
    pending_items.push_back(it);
    if (op != OP_UNUSED) item_total++;
  endtask

  // let everything drain, with extra settling time in case an ignored command is still in flight
  task automatic wait_drained();
    while (pending_items.size() != 0 || start || expected_answers.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GRID_ROWS) rows_cfg = value;
    else cols_cfg = value;
  endtask

  function automatic logic [4:0] pick_dim();
    logic [4:0] extremes[6] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
    if ($urandom_range(0, 3) == 0) return extremes[$urandom_range(0, 5)];
    return 5'($urandom_range(2, 16));
  endfunction

  // random mix of maze edits, searches mostly inside the grid, path reads and rare unused opcodes
  task automatic fill_phase(int n_ops);
    int nr, nc, pick;
    in_item_t it;
    nr = dim_in_use(rows_cfg);
    nc = dim_in_use(cols_cfg);
    repeat (n_ops) begin
      it = in_item_t'($bits(in_item_t)'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        it.opcode = OP_WRITE;
        if ($urandom_range(0, 9) != 0) begin
          it.row = 4'($urandom_range(0, nr - 1));
          it.col = 4'($urandom_range(0, nc - 1));
        end
        it.cell_open = ($urandom_range(0, 2) != 0);
      end else if (pick < 65) begin
        it.opcode = OP_SEARCH;
        if ($urandom_range(0, 9) != 0) begin
          it.row = 4'($urandom_range(0, nr - 1));
          it.col = 4'($urandom_range(0, nc - 1));
        end
      end else if (pick < 98) begin
        it.opcode = OP_READ;
        case ($urandom_range(0, 3))
          0, 1: it.path_index = 8'($urandom_range(0, 15));
          2: it.path_index = 8'($urandom_range(0, 63));
          default: ;
        endcase
      end else begin
        it.opcode = OP_UNUSED;
      end
      pending_items.push_back(it);
      if (it.opcode != OP_UNUSED) item_total++;
    end
  endtask

  initial begin
    int phase;
    logic [4:0] r_dim, c_dim;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // every cell gets a defined value before the first search
    for (int r = 0; r < DIM; r++)
      for (int c = 0; c < DIM; c++)
        push_item(OP_WRITE, 4'(r), 4'(c), 1'b0, 8'($urandom));

    push_item(OP_SEARCH, 4'd1, 4'd1, 1'b0, 8'd0);    // start on a wall
    push_item(OP_WRITE, 4'd1, 4'd1, 1'b1, 8'd255);
    push_item(OP_SEARCH, 4'd1, 4'd1, 1'b1, 8'd0);    // walled in, no path
    push_item(OP_READ, 4'd0, 4'd0, 1'b0, 8'd0);      // nothing stored
    push_item(OP_SEARCH, 4'd12, 4'd3, 1'b1, 8'd0);   // start below the grid
    push_item(OP_SEARCH, 4'd3, 4'd12, 1'b1, 8'd0);   // start right of the grid
    push_item(OP_WRITE, 4'd0, 4'd1, 1'b1, 8'd0);
    push_item(OP_SEARCH, 4'd1, 4'd1, 1'b0, 8'd255);  // exit north, two cells
    push_item(OP_READ, 4'd15, 4'd15, 1'b1, 8'd0);
    push_item(OP_READ, 4'd0, 4'd0, 1'b0, 8'd1);
    push_item(OP_READ, 4'd0, 4'd0, 1'b0, 8'd2);      // just past the end
    push_item(OP_READ, 4'd0, 4'd0, 1'b0, 8'd255);
    push_item(OP_SEARCH, 4'd0, 4'd1, 1'b0, 8'd0);    // start on the border
    push_item(OP_READ, 4'd0, 4'd0, 1'b0, 8'd0);
    push_item(OP_WRITE, 4'd15, 4'd15, 1'b1, 8'd0);
    push_item(OP_SEARCH, 4'd15, 4'd15, 1'b0, 8'd0);  // open but outside the grid
    push_item(OP_UNUSED, 4'd9, 4'd9, 1'b1, 8'd77);
    push_item(OP_READ, 4'd0, 4'd0, 1'b0, 8'd0);

    phase = 0;
    while (item_total < ITEM_TARGET) begin
      wait_drained();
      case (phase)
        0: begin r_dim = 5'd31; c_dim = 5'd31; end
        1: begin r_dim = 5'd0;  c_dim = 5'd1;  end
        2: begin r_dim = 5'd2;  c_dim = 5'd16; end
        3: begin r_dim = 5'd16; c_dim = 5'd2;  end
        default: begin r_dim = pick_dim(); c_dim = pick_dim(); end
      endcase
      write_reg(CFG_GRID_ROWS, r_dim);
      write_reg(CFG_GRID_COLS, c_dim);
      fill_phase($urandom_range(20, 60));
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
